/* hdl/assert_macros.svh */
// Assertion macros shared by the solver RTL.
// Depends on nothing; included by files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* hdl/gfps_pkg.sv */
// Package for the full-pivot solver: constants and shared types.
// No dependencies.
`timescale 1ns / 1ps
package gfps_pkg;
  localparam int unsigned MaxUnknowns = 16;
  localparam int unsigned FracBits    = 16;
  localparam int unsigned SizeReset   = 16;

  typedef enum logic [1:0] {
    StatOk       = 2'd0,
    StatSingular = 2'd1,
    StatOverflow = 2'd2
  } status_e;

  // control from sequencer to the shared arithmetic unit
  typedef enum logic [2:0] {
    OpDiv = 3'b001,
    OpMac = 3'b010,
    OpNop = 3'b100
  } alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic ovf;
  } alu_sts_t;

  function automatic logic [31:0] sat32(input logic signed [65:0] v, output logic o);
    logic [31:0] r;
    if (v > 66'sd2147483647) begin
      r = 32'h7fff_ffff;
      o = 1'b1;
    end else if (v < -66'sd2147483648) begin
      r = 32'h8000_0000;
      o = 1'b1;
    end else begin
      r = v[31:0];
      o = 1'b0;
    end
    return r;
  endfunction
endpackage

/* hdl/gfps_stream_if.sv */
// Valid/ready stream interface carrying a payload struct or vector.
// Depends on nothing.
`timescale 1ns / 1ps
interface gfps_stream_if #(
  parameter int unsigned W = 1
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hdl/gauss_full_pivot_solver.sv */
// Top level of the full-pivot Gaussian solver: load, sequencer, output.
// Depends on gfps_pkg, gfps_stream_if, gfps_ram, gfps_alu, assert_macros.svh.
`timescale 1ns / 1ps
// Loads an n-by-(n+1) augmented system row-major, one Q beat per element, then
// on the beat flagged last solves it by Gaussian elimination with complete
// pivoting and emits n result beats in original unknown order. Loading accepts
// one element per cycle. The solve runs on one shared unit: each pivot-row
// divide is a start, 32+FRAC_BITS restoring steps and a write back, and each
// elimination multiply-subtract three memory reads, a start and a write back.
// A solve is the copy, the pivot search (about n^3/3 reads), the row and
// column swaps and the elimination (about n^3/3 products); the matrix memory
// port sets the inner loop speed. Each result beat is read in SOut, registered
// in SOutW and held while the receiver stalls. The input is not ready during
// the solve or while results drain.
`include "assert_macros.svh"
module gauss_full_pivot_solver
  import gfps_pkg::*;
#(
  parameter int unsigned MAX_UNKNOWNS = MaxUnknowns,
  parameter int unsigned FRAC_BITS    = FracBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  gfps_stream_if.sink   in_i,
  gfps_stream_if.source out_o
);
  localparam int unsigned Words = MAX_UNKNOWNS * (MAX_UNKNOWNS + 1);
  localparam int unsigned AW    = $clog2(Words);
  localparam int unsigned CW    = $clog2(Words + 1);
  localparam int unsigned NW    = $clog2(MAX_UNKNOWNS + 2);
  localparam int unsigned XW    = $clog2(MAX_UNKNOWNS);

  typedef enum logic [15:0] {
    SLoad  = 16'h0001, SCopy  = 16'h0002, SCopyW = 16'h0004,
    SSrch  = 16'h0008, SSrchW = 16'h0010, SSwapR = 16'h0020,
    SSwapW = 16'h0040, SPivR  = 16'h0080, SDivR  = 16'h0100,
    SDivW  = 16'h0200, SElR   = 16'h0400, SElW   = 16'h0800,
    SBkR   = 16'h1000, SBkW   = 16'h2000, SOut   = 16'h4000,
    SOutW  = 16'h8000
  } state_e;

  state_e state_q, state_d;
  logic [4:0] size_q;
  logic [CW-1:0] lcnt_q, lcnt_d;
  logic [NW-1:0] n_q, n_d, p_q, p_d, r_q, r_d, c_q, c_d, mr_q, mr_d, mc_q, mc_d;
  logic [1:0]  sub_q, sub_d;     // micro step inside a state
  logic [31:0] mv_q, mv_d, t0_q, t0_d, t1_q, t1_d, piv_q, piv_d;
  logic        ovf_q, ovf_d, sing_q, sing_d;
  logic [XW-1:0] cord_q [MAX_UNKNOWNS];
  logic [XW-1:0] cord_d [MAX_UNKNOWNS];
  logic [XW:0] k_q, k_d;

  // store: loaded matrix; work: working copy; sol: solution RAM
  logic          st_we, wk_we, sl_we;
  logic [AW-1:0] st_wa, st_ra, wk_wa, wk_ra;
  logic [31:0]   st_wd, st_rd, wk_wd, wk_rd, sl_wd, sl_rd;
  logic [XW-1:0] sl_wa, sl_ra;
  alu_ctl_t actl;
  alu_sts_t asts;
  logic [31:0] aa, ab, ac, ares;

  gfps_ram #(.Width(32), .Depth(Words)) u_store (
    .clk_i, .we_i(st_we), .waddr_i(st_wa), .wdata_i(st_wd), .raddr_i(st_ra), .rdata_o(st_rd));
  gfps_ram #(.Width(32), .Depth(Words)) u_work (
    .clk_i, .we_i(wk_we), .waddr_i(wk_wa), .wdata_i(wk_wd), .raddr_i(wk_ra), .rdata_o(wk_rd));
  gfps_ram #(.Width(32), .Depth(MAX_UNKNOWNS)) u_sol (
    .clk_i, .we_i(sl_we), .waddr_i(sl_wa), .wdata_i(sl_wd), .raddr_i(sl_ra), .rdata_o(sl_rd));
  gfps_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (
    .clk_i, .rst_ni, .ctl_i(actl), .a_i(aa), .b_i(ab), .c_i(ac), .res_o(ares), .sts_o(asts));

  function automatic logic [AW-1:0] addr(input logic [NW-1:0] n, input logic [NW-1:0] r,
                                         input logic [NW-1:0] c);
    return AW'(32'(r) * (32'(n) + 32'd1) + 32'(c));
  endfunction
  function automatic logic [31:0] mag(input logic [31:0] v);
    return v[31] ? -v : v;   // 0x80000000 reads as 2^31 unsigned
  endfunction

  logic out_busy;
  logic [31:0] one_fx;
  assign one_fx = 32'd1 << FRAC_BITS;
  assign in_i.ready = (state_q == SLoad);
  logic in_acc;
  assign in_acc = in_i.valid && in_i.ready;
  assign out_busy = out_o.valid && !out_o.ready;

  always_comb begin
    state_d = state_q; lcnt_d = lcnt_q; n_d = n_q; p_d = p_q; r_d = r_q; c_d = c_q;
    mr_d = mr_q; mc_d = mc_q; sub_d = sub_q; mv_d = mv_q; t0_d = t0_q; t1_d = t1_q;
    piv_d = piv_q; ovf_d = ovf_q; sing_d = sing_q; cord_d = cord_q; k_d = k_q;
    st_we = 1'b0; st_wa = lcnt_q[AW-1:0]; st_wd = in_i.data[31:0]; st_ra = '0;
    wk_we = 1'b0; wk_wa = '0; wk_wd = '0; wk_ra = '0;
    sl_we = 1'b0; sl_wa = '0; sl_wd = '0; sl_ra = '0;
    actl = '{start: 1'b0, op: OpNop}; aa = '0; ab = '0; ac = '0;
    case (state_q)
      SLoad: begin
        if (in_acc) begin
          if (lcnt_q < CW'(Words)) begin
            st_we = 1'b1; lcnt_d = lcnt_q + 1'b1;
          end
          if (in_i.data[32]) begin
            n_d = (size_q < 5'd2) ? NW'(2)
                : (32'(size_q) > MAX_UNKNOWNS) ? NW'(MAX_UNKNOWNS) : NW'(size_q);
            lcnt_d = '0; r_d = '0; c_d = '0; ovf_d = 1'b0; sing_d = 1'b0; sub_d = '0;
            for (int i = 0; i < MAX_UNKNOWNS; i++) cord_d[i] = XW'(i);
            state_d = SCopy;
          end
        end
      end
      // copy store into work, one word at a time: SCopy reads, SCopyW writes
      SCopy: begin
        st_ra = addr(n_q, r_q, c_q); state_d = SCopyW;
      end
      SCopyW: begin
        wk_we = 1'b1; wk_wa = addr(n_q, r_q, c_q); wk_wd = st_rd;
        if (c_q == n_q) begin
          c_d = '0;
          if (r_q == n_q - 1'b1) begin
            p_d = '0; r_d = '0; c_d = '0; mv_d = '0; mr_d = '0; mc_d = '0;
            state_d = SSrch;
          end else begin
            r_d = r_q + 1'b1; state_d = SCopy;
          end
        end else begin
          c_d = c_q + 1'b1; state_d = SCopy;
        end
      end
      // search remaining submatrix, starting from (p,p) with strict greater
      SSrch: begin
        wk_ra = addr(n_q, p_q + r_q, p_q + c_q); state_d = SSrchW;
      end
      SSrchW: begin
        if ((r_q == '0 && c_q == '0) || mag(wk_rd) > mv_q) begin
          mv_d = mag(wk_rd); mr_d = p_q + r_q; mc_d = p_q + c_q;
        end
        state_d = SSrch;
        if (p_q + c_q == n_q - 1'b1) begin
          c_d = '0;
          if (p_q + r_q == n_q - 1'b1) begin
            r_d = '0; c_d = '0; sub_d = '0; state_d = SSwapR;
            if (!((r_q == '0 && c_q == '0) || mag(wk_rd) > mv_q) && mv_q == '0) begin
              sing_d = 1'b1; k_d = '0; state_d = SOut;
            end else if (((r_q == '0 && c_q == '0) || mag(wk_rd) > mv_q)
                         && mag(wk_rd) == '0) begin
              sing_d = 1'b1; k_d = '0; state_d = SOut;
            end
          end else r_d = r_q + 1'b1;
        end else c_d = c_q + 1'b1;
      end
      // row swap over c = 0..n (sub 0), then column swap over r = 0..n-1 (sub 1)
      SSwapR: begin
        if (sub_q == 2'd0) wk_ra = addr(n_q, p_q, c_q);
        else wk_ra = addr(n_q, r_q, p_q);
        state_d = SSwapW; t1_d = '0;
      end
      SSwapW: begin
        // first visit latches word A and reads B; second visit writes B over A
        if (t1_q == '0 && sub_q[1] == 1'b0) begin
          t0_d = wk_rd; sub_d = {1'b1, sub_q[0]};
          if (sub_q[0] == 1'b0) wk_ra = addr(n_q, mr_q, c_q);
          else wk_ra = addr(n_q, r_q, mc_q);
        end else if (sub_q[1]) begin
          t1_d = wk_rd; sub_d = {1'b0, sub_q[0]}; t1_d[0] = t1_d[0];
          wk_we = 1'b1;
          if (sub_q[0] == 1'b0) begin
            wk_wa = addr(n_q, p_q, c_q); wk_wd = wk_rd;
          end else begin
            wk_wa = addr(n_q, r_q, p_q); wk_wd = wk_rd;
          end
          state_d = SPivR; // write second word next
        end
      end
      SPivR: begin
        // complete the swap: old A goes to the partner location
        wk_we = 1'b1;
        if (sub_q[0] == 1'b0) begin
          wk_wa = addr(n_q, mr_q, c_q); wk_wd = t0_q;
          if (c_q == n_q) begin
            c_d = '0; r_d = '0; sub_d = 2'd1;
          end else c_d = c_q + 1'b1;
          state_d = SSwapR;
        end else begin
          wk_wa = addr(n_q, r_q, mc_q); wk_wd = t0_q;
          if (r_q == n_q - 1'b1) begin
            cord_d[p_q[XW-1:0]] = cord_q[mc_q[XW-1:0]];
            cord_d[mc_q[XW-1:0]] = cord_q[p_q[XW-1:0]];
            r_d = '0; c_d = p_q + 1'b1; sub_d = '0; state_d = SDivR;
          end else begin
            r_d = r_q + 1'b1; state_d = SSwapR;
          end
        end
      end
      // normalise pivot row: sub 0 read pivot, 1 latch, 2 divide loop
      SDivR: begin
        case (sub_q)
          2'd0: begin wk_ra = addr(n_q, p_q, p_q); sub_d = 2'd1; end
          2'd1: begin piv_d = wk_rd; wk_ra = addr(n_q, p_q, c_q); sub_d = 2'd2; end
          2'd2: begin
            actl = '{start: 1'b1, op: OpDiv}; aa = wk_rd; ab = piv_q;
            state_d = SDivW;
          end
          default: sub_d = 2'd0;
        endcase
      end
      SDivW: begin
        if (asts.done) begin
          wk_we = 1'b1; wk_wa = addr(n_q, p_q, c_q); wk_wd = ares;
          ovf_d = ovf_q | asts.ovf;
          if (c_q == n_q) begin
            r_d = p_q + 1'b1; c_d = p_q + 1'b1; sub_d = '0; state_d = SElR;
          end else begin
            // next element read here, pivot kept: go straight to the divide
            c_d = c_q + 1'b1; sub_d = 2'd2; state_d = SDivR;
            wk_ra = addr(n_q, p_q, c_q + 1'b1); piv_d = piv_q;
          end
        end
      end
      // eliminate: sub 0 read f, 1 read pivot row, 2 read target, 3 start
      SElR: begin
        if (r_q == n_q) begin
          // write pivot 1.0 and move on
          wk_we = 1'b1; wk_wa = addr(n_q, p_q, p_q); wk_wd = one_fx;
          if (p_q == n_q - 1'b1) begin
            r_d = n_q - 1'b1; c_d = n_q; state_d = SBkR; sub_d = '0;
          end else begin
            p_d = p_q + 1'b1; r_d = '0; c_d = '0; state_d = SSrch;
          end
        end else begin
          case (sub_q)
            2'd0: begin wk_ra = addr(n_q, r_q, p_q); sub_d = 2'd1; end
            2'd1: begin
              if (c_q == p_q + 1'b1) piv_d = wk_rd;  // piv_q holds factor f
              wk_ra = addr(n_q, p_q, c_q); sub_d = 2'd2;
            end
            2'd2: begin t0_d = wk_rd; wk_ra = addr(n_q, r_q, c_q); sub_d = 2'd3; end
            default: begin
              actl = '{start: 1'b1, op: OpMac}; aa = wk_rd; ab = piv_q; ac = t0_q;
              state_d = SElW;
            end
          endcase
        end
      end
      SElW: begin
        if (asts.done) begin
          wk_we = 1'b1; wk_wa = addr(n_q, r_q, c_q); wk_wd = ares;
          ovf_d = ovf_q | asts.ovf; state_d = SElR;
          if (c_q == n_q) begin
            sub_d = 2'd3; t1_d = '0; state_d = SBkW; // clear a[r][p]
          end else begin
            c_d = c_q + 1'b1; sub_d = 2'd1; wk_ra = addr(n_q, r_q, p_q);
          end
        end
      end
      // back substitution: x[r] kept in the solution RAM by row index,
      // then permuted on output. sub 3 here clears a[r][p] during elimination.
      SBkR: begin
        case (sub_q)
          2'd0: begin wk_ra = addr(n_q, r_q, n_q); sub_d = 2'd1; end
          2'd1: begin
            t1_d = wk_rd; c_d = r_q + 1'b1; sub_d = 2'd2;
            wk_ra = addr(n_q, r_q, r_q + 1'b1); sl_ra = XW'(r_q + 1'b1);
          end
          default: begin
            if (c_q == n_q) begin
              sl_we = 1'b1; sl_wa = r_q[XW-1:0]; sl_wd = t1_q;
              if (r_q == '0) begin
                k_d = '0; state_d = SOut;
              end else begin
                r_d = r_q - 1'b1; sub_d = '0;
              end
            end else begin
              actl = '{start: 1'b1, op: OpMac}; aa = t1_q; ab = wk_rd; ac = sl_rd;
              state_d = SBkW; sub_d = 2'd2;
            end
          end
        endcase
      end
      SBkW: begin
        if (sub_q == 2'd3) begin
          wk_we = 1'b1; wk_wa = addr(n_q, r_q, p_q); wk_wd = '0;
          r_d = r_q + 1'b1; c_d = p_q + 1'b1; sub_d = '0; state_d = SElR;
        end else if (asts.done) begin
          t1_d = ares; ovf_d = ovf_q | asts.ovf; c_d = c_q + 1'b1; state_d = SBkR;
          wk_ra = addr(n_q, r_q, c_q + 1'b1); sl_ra = XW'(c_q + 1'b1);
        end
      end
      // output: find row whose column order equals k, read its x
      SOut: begin
        if (!out_busy) begin
          sl_ra = '0;
          for (int i = 0; i < MAX_UNKNOWNS; i++)
            if (32'(i) < 32'(n_q) && cord_q[i] == k_q[XW-1:0]) sl_ra = XW'(i);
          state_d = SOutW;
        end
      end
      SOutW: begin
        if (out_o.valid && out_o.ready) begin
          if (k_q == (XW+1)'(n_q - 1'b1)) state_d = SLoad;
          else begin
            k_d = k_q + 1'b1; state_d = SOut;
          end
        end
      end
      default: state_d = SLoad;
    endcase
  end

  // output beat register
  logic ov_q;
  logic [38:0] od_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (state_q == SOut && !out_busy) begin
      ov_q <= 1'b0;
    end else if (state_q == SOutW && !ov_q && !(out_o.valid && out_o.ready)) begin
      ov_q <= 1'b1;
    end else if (out_o.valid && out_o.ready) begin
      ov_q <= 1'b0;
    end
  end
  always_ff @(posedge clk_i) begin
    if (state_q == SOutW && !ov_q) begin
      od_q[3:0]   <= k_q[3:0];
      od_q[35:4]  <= sing_q ? 32'd0 : sl_rd;
      od_q[36]    <= (k_q == (XW+1)'(n_q - 1'b1));
      od_q[38:37] <= sing_q ? StatSingular : (ovf_q ? StatOverflow : StatOk);
    end
  end
  assign out_o.valid = ov_q;
  assign out_o.data  = od_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SLoad; size_q <= 5'(SizeReset); lcnt_q <= '0;
      n_q <= NW'(MAX_UNKNOWNS); p_q <= '0; r_q <= '0; c_q <= '0;
      mr_q <= '0; mc_q <= '0; sub_q <= '0; ovf_q <= 1'b0; sing_q <= 1'b0; k_q <= '0;
      for (int i = 0; i < MAX_UNKNOWNS; i++) cord_q[i] <= XW'(i);
    end else begin
      state_q <= state_d; lcnt_q <= lcnt_d; n_q <= n_d; p_q <= p_d; r_q <= r_d;
      c_q <= c_d; mr_q <= mr_d; mc_q <= mc_d; sub_q <= sub_d; ovf_q <= ovf_d;
      sing_q <= sing_d; k_q <= k_d; cord_q <= cord_d;
      if (cfg_we_i) size_q <= cfg_wdata_i;
    end
  end
  always_ff @(posedge clk_i) begin
    mv_q <= mv_d; t0_q <= t0_d; t1_q <= t1_d; piv_q <= piv_d;
  end

  `ASSERT_IMP(a_ready_only_load, clk_i, rst_ni, in_i.ready, !out_o.valid)
  `ASSERT_IMP(a_count_bound, clk_i, rst_ni, 1'b1, lcnt_q <= CW'(Words))
  `ASSERT_NXT(a_start_clears, clk_i, rst_ni, in_acc && in_i.data[32], lcnt_q == '0)
endmodule

/* hdl/gfps_ram.sv */
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module gfps_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* hdl/gfps_alu.sv */
// Shared arithmetic unit: bit-serial restoring divider for Q quotients and a
// multiply-subtract with saturation. Depends on gfps_pkg.
`timescale 1ns / 1ps
module gfps_alu
  import gfps_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FracBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  alu_ctl_t    ctl_i,
  input  logic [31:0] a_i,   // dividend or minuend
  input  logic [31:0] b_i,   // divisor or multiplicand
  input  logic [31:0] c_i,   // multiplier
  output logic [31:0] res_o,
  output alu_sts_t    sts_o
);
  localparam int unsigned NumW = 32 + FRAC_BITS;
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic            busy_q, busy_d, done_q, done_d, ovf_q, ovf_d;
  alu_op_e         op_q, op_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [NumW-1:0] num_q, num_d;     // dividend magnitude, shifts out
  logic [32:0]     rem_q, rem_d;
  logic [31:0]     den_q, den_d;     // divisor magnitude
  logic            neg_q, neg_d;
  logic signed [63:0] prod_q, prod_d;
  logic signed [31:0] acc_q, acc_d;
  logic [31:0]     res_q, res_d;
  logic [32:0]     trial;
  logic signed [65:0] wide;
  logic            sov;
  logic [31:0]     sres;
  logic signed [63:0] pq;

  // quotient bits collected in num_q as dividend bits leave
  assign trial = {rem_q[31:0], num_q[NumW-1]} - {1'b0, den_q};
  always_comb begin
    pq = prod_q >>> FRAC_BITS;
    if (prod_q < 0 && (prod_q & ((64'sd1 <<< FRAC_BITS) - 1)) != 0) pq = pq + 64'sd1;
  end

  always_comb begin
    busy_d = busy_q; done_d = 1'b0; ovf_d = 1'b0; op_d = op_q; cnt_d = cnt_q;
    num_d = num_q; rem_d = rem_q; den_d = den_q; neg_d = neg_q; prod_d = prod_q;
    acc_d = acc_q; res_d = res_q; wide = '0; sov = 1'b0; sres = '0;
    if (!busy_q) begin
      if (ctl_i.start) begin
        busy_d = 1'b1; op_d = ctl_i.op; cnt_d = '0;
        if (ctl_i.op == OpDiv) begin
          num_d = {(a_i[31] ? -a_i : a_i), {FRAC_BITS{1'b0}}};
          den_d = b_i[31] ? -b_i : b_i;
          neg_d = a_i[31] ^ b_i[31];
          rem_d = '0;
        end else begin
          acc_d  = a_i;
          prod_d = $signed(b_i) * $signed(c_i);
        end
      end
    end else begin
      case (op_q)
        OpDiv: begin
          if (!trial[32]) rem_d = trial;
          else rem_d = {rem_q[31:0], num_q[NumW-1]};
          num_d = {num_q[NumW-2:0], ~trial[32]};
          cnt_d = cnt_q + 1'b1;
          if (cnt_q == CntW'(NumW - 1)) begin
            busy_d = 1'b0; done_d = 1'b1;
            wide = 66'(num_d);
            if (neg_q) wide = -wide;
            sres = sat32(wide, sov);
            res_d = sres; ovf_d = sov;
          end
        end
        OpMac: begin
          busy_d = 1'b0; done_d = 1'b1;
          wide = 66'(acc_q) - 66'(pq);
          sres = sat32(wide, sov);
          res_d = sres; ovf_d = sov;
        end
        default: begin
          busy_d = 1'b0; done_d = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; ovf_q <= 1'b0; op_q <= OpNop; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; ovf_q <= ovf_d; op_q <= op_d; cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    num_q <= num_d; rem_q <= rem_d; den_q <= den_d; neg_q <= neg_d;
    prod_q <= prod_d; acc_q <= acc_d; res_q <= res_d;
  end

  assign res_o = res_q;
  assign sts_o = '{busy: busy_q, done: done_q, ovf: ovf_q};
endmodule

/* tb/testbench.sv */
// Self-checking bench for gauss_full_pivot_solver: loads augmented systems,
// predicts the solutions in a scoreboard class and checks every result beat.
// Depends on gfps_pkg, gfps_stream_if and the solver RTL.
`timescale 1ns / 1ps
module testbench;
  import gfps_pkg::*;

  localparam int unsigned StoreWords = MaxUnknowns * (MaxUnknowns + 1);
  localparam longint      CycleLimit = 1_500_000;

  // Result beat layout, index in the low bits.
  typedef struct packed {
    status_e     stat;
    logic        last;
    logic [31:0] val;
    logic [3:0]  idx;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [4:0] cfg_wdata_i = '0;

  gfps_stream_if #(.W(33)) in_if ();
  gfps_stream_if #(.W(39)) out_if ();

  initial begin
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
  end

  gauss_full_pivot_solver u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Scoreboard: a private copy of the solver state, a fixed-point predictor
  // and the queue of solutions still owed by the block.
  class solution_board;
    int          words[StoreWords];
    int unsigned fill;
    logic [4:0]  size_reg;
    answer_t     owed[$];
    int          errors;
    int          solves, singulars, overflows, beats_seen;

    function new();
      foreach (words[i]) words[i] = 0;
      fill = 0;
      size_reg = 5'(SizeReset);
      errors = 0;
      solves = 0;
      singulars = 0;
      overflows = 0;
      beats_seen = 0;
    endfunction

    function void set_size(logic [4:0] v);
      size_reg = v;
    endfunction

    function int clip(longint v, inout bit ovf);
      if (v > 64'sd2147483647) begin
        ovf = 1'b1;
        return 32'sh7fff_ffff;
      end
      if (v < -64'sd2147483648) begin
        ovf = 1'b1;
        return 32'sh8000_0000;
      end
      return int'(v);
    endfunction

    function longint mag(int v);
      longint w;
      w = v;
      return (w < 0) ? -w : w;
    endfunction

    function longint qmul(int x, int y);
      longint p;
      p = longint'(x) * longint'(y);
      return p / (64'sd1 <<< FracBits);
    endfunction

    // Complete-pivot elimination on a copy of the store.
    function void solve_system(int n);
      int a[MaxUnknowns][MaxUnknowns + 1];
      int ord[MaxUnknowns];
      int x[MaxUnknowns];
      int sol[MaxUnknowns];
      bit ovf, sing;
      int mr, mc, t, piv, f, s;
      longint mv;
      answer_t ans;
      ovf = 0;
      sing = 0;
      for (int r = 0; r < n; r++) begin
        for (int c = 0; c <= n; c++) a[r][c] = words[r * (n + 1) + c];
        ord[r] = r;
      end
      for (int p = 0; p < n; p++) begin
        mr = p;
        mc = p;
        mv = mag(a[p][p]);
        for (int r = p; r < n; r++)
          for (int c = p; c < n; c++)
            if (mag(a[r][c]) > mv) begin
              mv = mag(a[r][c]);
              mr = r;
              mc = c;
            end
        if (mv == 0) begin
          sing = 1;
          break;
        end
        for (int c = 0; c <= n; c++) begin
          t = a[p][c]; a[p][c] = a[mr][c]; a[mr][c] = t;
        end
        for (int r = 0; r < n; r++) begin
          t = a[r][p]; a[r][p] = a[r][mc]; a[r][mc] = t;
        end
        t = ord[p]; ord[p] = ord[mc]; ord[mc] = t;
        piv = a[p][p];
        for (int c = p + 1; c <= n; c++)
          a[p][c] = clip((longint'(a[p][c]) * (64'sd1 <<< FracBits)) / longint'(piv), ovf);
        a[p][p] = 1 << FracBits;
        for (int r = p + 1; r < n; r++) begin
          f = a[r][p];
          for (int c = p + 1; c <= n; c++)
            a[r][c] = clip(longint'(a[r][c]) - qmul(f, a[p][c]), ovf);
          a[r][p] = 0;
        end
      end
      if (sing) begin
        for (int r = 0; r < n; r++) sol[r] = 0;
      end else begin
        for (int r = n - 1; r >= 0; r--) begin
          s = a[r][n];
          for (int c = r + 1; c < n; c++) s = clip(longint'(s) - qmul(a[r][c], x[c]), ovf);
          x[r] = s;
        end
        for (int r = 0; r < n; r++) sol[ord[r]] = x[r];
      end
      solves++;
      if (sing) singulars++;
      else if (ovf) overflows++;
      for (int k = 0; k < n; k++) begin
        ans.idx = 4'(k);
        ans.val = sol[k];
        ans.last = (k == n - 1);
        ans.stat = sing ? StatSingular : (ovf ? StatOverflow : StatOk);
        owed.push_back(ans);
      end
    endfunction

    // Accepted input beat.
    function void note_element(logic [31:0] v, logic last);
      int n;
      if (fill < StoreWords) begin
        words[fill] = v;
        fill++;
      end
      if (last) begin
        n = size_reg;
        if (n < 2) n = 2;
        if (n > MaxUnknowns) n = MaxUnknowns;
        solve_system(n);
        fill = 0;
      end
    endfunction

    task report_mismatch(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    // Accepted result beat.
    task check_answer(answer_t got);
      answer_t want;
      beats_seen++;
      if (owed.size() == 0) begin
        report_mismatch($sformatf("unexpected result idx=%0d val=%h", got.idx, got.val));
        return;
      end
      want = owed.pop_front();
      if (got.idx !== want.idx)
        report_mismatch($sformatf("index %0d, want %0d", got.idx, want.idx));
      if (got.val !== want.val)
        report_mismatch($sformatf("unknown %0d value %h, want %h", want.idx, got.val, want.val));
      if (got.last !== want.last)
        report_mismatch($sformatf("unknown %0d last flag %b, want %b", want.idx, got.last,
                                  want.last));
      if (got.stat !== want.stat)
        report_mismatch($sformatf("unknown %0d status %0d, want %0d", want.idx, got.stat,
                                  want.stat));
    endtask
  endclass

  solution_board board = new();

  int     send_idle_pct = 12;
  int     recv_idle_pct = 55;
  int     hold_request = 0;
  longint cycles = 0;
  int     items_sent = 0;

  // Watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  // Receiver: random back-pressure plus a requested long hold-off.
  initial begin : receiver
    int hold;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) board.check_answer(answer_t'(out_if.data));
      if (hold_request > 0) begin
        hold = hold_request;
        hold_request = 0;
      end
      if (hold > 0) begin
        hold--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // One element beat; valid stays high between back-to-back beats.
  task automatic send_element(logic [31:0] v, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data <= {last, v};
    do @(posedge clk_i); while (!in_if.ready);
    board.note_element(v, last);
    items_sent++;
  endtask

  // Register write only when nothing is owed and the block is quiet.
  task automatic write_size(logic [4:0] v);
    in_if.valid <= 1'b0;
    while (board.owed.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.set_size(v);
  endtask

  // Random element: small values mostly keep the system well conditioned.
  function automatic logic [31:0] rand_element(int style);
    case (style)
      0: return 32'($signed($urandom_range(16 * 65536)) - 8 * 65536);
      1: return $urandom();
      default: return ($urandom_range(3) == 0) ? 32'h0 : 32'($signed($urandom_range(512)) - 256);
    endcase
  endfunction

  // Full system load of n(n+1) elements, last flag on the final one.
  task automatic load_system(int n, int style);
    int total;
    total = n * (n + 1);
    for (int k = 0; k < total; k++) send_element(rand_element(style), k == total - 1);
  endtask

  initial begin : stimulus
    int n, style;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_size(5'd2);
    // Extremes of the element range; overflow on normalisation.
    send_element(32'h8000_0000, 0); send_element(32'h0000_0001, 0);
    send_element(32'h7fff_ffff, 0); send_element(32'h0000_0001, 0);
    send_element(32'hffff_ffff, 0); send_element(32'h7fff_ffff, 1);
    // Singular: all zero.
    for (int k = 0; k < 6; k++) send_element(32'h0, k == 5);
    // Exact identity system.
    send_element(32'h0001_0000, 0); send_element(32'h0, 0); send_element(32'h0005_0000, 0);
    send_element(32'h0, 0); send_element(32'h0001_0000, 0); send_element(32'hfffd_0000, 1);
    // Early start: reads words left from earlier loads.
    send_element(32'h0003_0000, 0); send_element(32'h0002_0000, 1);

    // Size below the range clamps to two.
    write_size(5'd0);
    load_system(2, 0);
    write_size(5'd3);
    load_system(3, 0);
    // Early start at size three reuses the rest of that load.
    send_element(32'h0004_0000, 1);

    // Random part in three idling phases.
    hold_request = 400;
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        send_idle_pct = 55;
        recv_idle_pct = 12;
      end else if (ph == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      n = $urandom_range(3, 2);
      write_size(5'(n));
      for (int sys = 0; sys < 3; sys++) begin
        style = $urandom_range(9);
        if (style == 0) begin
          // Broken sequence: early start mid-load.
          for (int k = $urandom_range(n); k >= 0; k--) send_element(rand_element(1), k == 0);
        end else begin
          load_system(n, (style < 6) ? 0 : ((style < 8) ? 1 : 2));
        end
      end
    end

    in_if.valid <= 1'b0;
    while (board.owed.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);

    $display("run covered %0d element beats, %0d solves (%0d singular, %0d overflowed)",
             items_sent, board.solves, board.singulars, board.overflows);
    $display("%0d result beats checked, %0d mismatches", board.beats_seen, board.errors);
    if (board.errors == 0 && board.owed.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

/* gauss_full_pivot_solver.f */
+incdir+hdl
hdl/gfps_pkg.sv
hdl/gfps_stream_if.sv
hdl/gfps_ram.sv
hdl/gfps_alu.sv
hdl/gauss_full_pivot_solver.sv
tb/testbench.sv
